### sv/mwm_pkg.sv
package mwm_pkg;

  localparam int VEL_W      = 16;
  localparam int OFF_W      = 16;
  localparam int DIST_W     = 15;
  localparam int MAX_W      = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = 48;
  localparam int ROT_SHIFT  = 28;
  localparam int ROT_HALF   = 1 << (ROT_SHIFT - 1);
  localparam int WHL_W      = 20;
  localparam int MAG_W      = 19;
  localparam int OUT_W      = 20;
  localparam int NWHL       = 4;
  localparam int SP_W       = MAG_W + MAX_W;
  localparam int NUM_W      = SP_W + 1;
  localparam int DEN_W      = MAG_W + 1;
  localparam int Q_W        = MAX_W;
  localparam int FRONT_N    = 7;

  localparam logic signed [OFF_W:0]  ONE_Q14  = (OFF_W + 1)'(16384);
  localparam logic signed [OFF_W-1:0] OFF_RST = '0;
  localparam logic [DIST_W-1:0]      DIST_RST = DIST_W'(3277);
  localparam logic [MAX_W-1:0]       MAX_RST  = MAX_W'(16384);

  localparam logic signed [WHL_W-1:0] SAT_HI = WHL_W'((1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [WHL_W-1:0] SAT_LO = WHL_W'(-(1 <<< (OUT_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_OFFSET,
    REG_WHEEL_DIST,
    REG_MAX_SPEED
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_front;
    logic signed [COEF_W-1:0] coef_rear;
    logic [MAX_W-1:0]         max_speed;
  } coef_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
    logic                    raw_mode;
  } cmd_t;

  typedef struct packed {
    logic [NWHL-1:0][NUM_W-1:0] rem;
    logic [DEN_W-1:0]           den;
    logic [NWHL-1:0][Q_W-1:0]   quo;
    logic [NWHL-1:0]            neg;
    logic [NWHL-1:0][WHL_W-1:0] whl;
    logic                       scale;
  } div_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WHL_W-1:0] x);
    logic signed [WHL_W-1:0] y;
    y = x;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end
    return OUT_W'(y);
  endfunction

endpackage

### sv/mwm_in_if.sv
interface mwm_in_if;
  import mwm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] yaw_rate;
  logic                    raw_mode;

  modport source (output valid, output vel_x, output vel_y, output yaw_rate,
                  output raw_mode, input ready);
  modport sink (input valid, input vel_x, input vel_y, input yaw_rate,
                input raw_mode, output ready);
endinterface

### sv/mwm_out_if.sv
interface mwm_out_if;
  import mwm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] wheel_front_a;
  logic signed [OUT_W-1:0] wheel_front_b;
  logic signed [OUT_W-1:0] wheel_rear_a;
  logic signed [OUT_W-1:0] wheel_rear_b;
  logic                    was_scaled;

  modport source (output valid, output wheel_front_a, output wheel_front_b,
                  output wheel_rear_a, output wheel_rear_b, output was_scaled,
                  input ready);
  modport sink (input valid, input wheel_front_a, input wheel_front_b,
                input wheel_rear_a, input wheel_rear_b, input was_scaled,
                output ready);
endinterface

### sv/mwm_cfg_if.sv
interface mwm_cfg_if;
  import mwm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/mwm_cfg_regs.sv
module mwm_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  mwm_cfg_if.sink       cfg_ch,
  output mwm_pkg::coef_t coef
);
  import mwm_pkg::*;

  logic signed [OFF_W-1:0]  off_r, off_nxt;
  logic [DIST_W-1:0]        dist_r, dist_nxt;
  logic [MAX_W-1:0]         max_r, max_nxt;
  logic signed [COEF_W-1:0] coef_front_r, coef_front_nxt;
  logic signed [COEF_W-1:0] coef_rear_r, coef_rear_nxt;
  logic signed [OFF_W:0]    off_ext;
  logic signed [COEF_W-1:0] fac_front, fac_rear, dist_s;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    off_nxt  = off_r;
    dist_nxt = dist_r;
    max_nxt  = max_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_ROT_OFFSET: off_nxt  = cfg_ch.data[OFF_W-1:0];
        REG_WHEEL_DIST: dist_nxt = cfg_ch.data[DIST_W-1:0];
        REG_MAX_SPEED:  max_nxt  = cfg_ch.data[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // front factor is offset - 1, rear factor is -offset - 1, both Q3.14
  always_comb begin
    off_ext        = (OFF_W + 1)'(off_r);
    fac_front      = COEF_W'(off_ext - ONE_Q14);
    fac_rear       = COEF_W'(-off_ext - ONE_Q14);
    dist_s         = $signed(COEF_W'(dist_r));
    coef_front_nxt = fac_front * dist_s;
    coef_rear_nxt  = fac_rear * dist_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= OFF_RST;
      dist_r <= DIST_RST;
      max_r  <= MAX_RST;
    end else begin
      off_r  <= off_nxt;
      dist_r <= dist_nxt;
      max_r  <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_front_r <= coef_front_nxt;
    coef_rear_r  <= coef_rear_nxt;
  end

  assign coef.coef_front = coef_front_r;
  assign coef.coef_rear  = coef_rear_r;
  assign coef.max_speed  = max_r;

endmodule

### sv/mwm_mix_front.sv
module mwm_mix_front (
  input  logic           clk,
  input  logic           rst_n,
  input  mwm_pkg::coef_t coef,
  input  logic           up_valid,
  output logic           up_ready,
  input  mwm_pkg::cmd_t  up_cmd,
  output logic           dn_valid,
  input  logic           dn_ready,
  output mwm_pkg::div_t  dn_word
);
  import mwm_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] rot_front;
    logic signed [PROD_W-1:0] rot_rear;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic                     raw_mode;
  } prod_t;

  typedef struct packed {
    logic [NWHL-1:0][WHL_W-1:0] whl;
    logic                       raw_mode;
  } mix_t;

  typedef struct packed {
    logic [NWHL-1:0][MAG_W-1:0] mag;
    logic [NWHL-1:0]            neg;
    logic [NWHL-1:0][WHL_W-1:0] whl;
    logic                       raw_mode;
  } abs_t;

  typedef struct packed {
    logic [NWHL-1:0][MAG_W-1:0] mag;
    logic [NWHL-1:0]            neg;
    logic [NWHL-1:0][WHL_W-1:0] whl;
    logic [MAG_W-1:0]           largest;
    logic                       scale;
  } peak_t;

  typedef struct packed {
    logic [NWHL-1:0][SP_W-1:0]  sp;
    logic [NWHL-1:0]            neg;
    logic [NWHL-1:0][WHL_W-1:0] whl;
    logic [MAG_W-1:0]           largest;
    logic                       scale;
  } scl_t;

  logic [FRONT_N-1:0] v_r, v_nxt, en;

  cmd_t  s1_r;
  prod_t s2_r, s2_nxt;
  mix_t  s3_r, s3_nxt;
  abs_t  s4_r, s4_nxt;
  peak_t s5_r, s5_nxt;
  scl_t  s6_r, s6_nxt;
  div_t  s7_r, s7_nxt;

  logic signed [PROD_W-1:0] rnd_front, rnd_rear;
  logic signed [WHL_W-1:0]  rot_front, rot_rear, vx_e, vy_e;
  logic [MAG_W-1:0]         peak_a, peak_b;

  // advance a stage when it is empty or the next one advances
  assign en[FRONT_N-1] = ~v_r[FRONT_N-1] | dn_ready;
  for (genvar k = 0; k < FRONT_N - 1; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end

  assign v_nxt    = (en & {v_r[FRONT_N-2:0], up_valid}) | (~en & v_r);
  assign up_ready = en[0];
  assign dn_valid = v_r[FRONT_N-1];
  assign dn_word  = s7_r;

  always_comb begin
    s2_nxt.rot_front = PROD_W'(coef.coef_front) * PROD_W'(s1_r.yaw_rate);
    s2_nxt.rot_rear  = PROD_W'(coef.coef_rear) * PROD_W'(s1_r.yaw_rate);
    s2_nxt.vel_x     = s1_r.vel_x;
    s2_nxt.vel_y     = s1_r.vel_y;
    s2_nxt.raw_mode  = s1_r.raw_mode;
  end

  // round the rotation term to nearest, halves up, then mix
  always_comb begin
    rnd_front       = s2_r.rot_front + PROD_W'(ROT_HALF);
    rnd_rear        = s2_r.rot_rear + PROD_W'(ROT_HALF);
    rot_front       = rnd_front[ROT_SHIFT +: WHL_W];
    rot_rear        = rnd_rear[ROT_SHIFT +: WHL_W];
    vx_e            = WHL_W'(s2_r.vel_x);
    vy_e            = WHL_W'(s2_r.vel_y);
    s3_nxt.whl[0]   = rot_front - vx_e - vy_e;
    s3_nxt.whl[1]   = rot_front + vx_e - vy_e;
    s3_nxt.whl[2]   = rot_rear + vx_e + vy_e;
    s3_nxt.whl[3]   = rot_rear - vx_e + vy_e;
    s3_nxt.raw_mode = s2_r.raw_mode;
  end

  always_comb begin
    s4_nxt.whl      = s3_r.whl;
    s4_nxt.raw_mode = s3_r.raw_mode;
    for (int l = 0; l < NWHL; l++) begin
      s4_nxt.neg[l] = s3_r.whl[l][WHL_W-1];
      s4_nxt.mag[l] = MAG_W'(s3_r.whl[l][WHL_W-1] ? -$signed(s3_r.whl[l])
                                                  : $signed(s3_r.whl[l]));
    end
  end

  always_comb begin
    peak_a         = (s4_r.mag[0] >= s4_r.mag[1]) ? s4_r.mag[0] : s4_r.mag[1];
    peak_b         = (s4_r.mag[2] >= s4_r.mag[3]) ? s4_r.mag[2] : s4_r.mag[3];
    s5_nxt.mag     = s4_r.mag;
    s5_nxt.neg     = s4_r.neg;
    s5_nxt.whl     = s4_r.whl;
    s5_nxt.largest = (peak_a >= peak_b) ? peak_a : peak_b;
    s5_nxt.scale   = ~s4_r.raw_mode & (s5_nxt.largest > MAG_W'(coef.max_speed));
  end

  always_comb begin
    s6_nxt.neg     = s5_r.neg;
    s6_nxt.whl     = s5_r.whl;
    s6_nxt.largest = s5_r.largest;
    s6_nxt.scale   = s5_r.scale;
    for (int l = 0; l < NWHL; l++) begin
      s6_nxt.sp[l] = SP_W'(s5_r.mag[l]) * SP_W'(coef.max_speed);
    end
  end

  // numerator 2*|w|*max + largest over 2*largest rounds halves away from zero
  always_comb begin
    s7_nxt.den   = {s6_r.largest, 1'b0};
    s7_nxt.quo   = '0;
    s7_nxt.neg   = s6_r.neg;
    s7_nxt.whl   = s6_r.whl;
    s7_nxt.scale = s6_r.scale;
    for (int l = 0; l < NWHL; l++) begin
      s7_nxt.rem[l] = {s6_r.sp[l], 1'b0} + NUM_W'(s6_r.largest);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= up_cmd;
    end
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
    if (en[3]) begin
      s4_r <= s4_nxt;
    end
    if (en[4]) begin
      s5_r <= s5_nxt;
    end
    if (en[5]) begin
      s6_r <= s6_nxt;
    end
    if (en[6]) begin
      s7_r <= s7_nxt;
    end
  end

endmodule

### sv/mwm_div_pipe.sv
module mwm_div_pipe (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  mwm_pkg::div_t up_word,
  output logic          dn_valid,
  input  logic          dn_ready,
  output mwm_pkg::div_t dn_word
);
  import mwm_pkg::*;

  logic [Q_W-1:0] v_r, v_nxt, en;
  div_t           st_r [Q_W];
  div_t           link [Q_W+1];

  assign en[Q_W-1] = ~v_r[Q_W-1] | dn_ready;
  for (genvar k = 0; k < Q_W - 1; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end

  assign v_nxt    = (en & {v_r[Q_W-2:0], up_valid}) | (~en & v_r);
  assign up_ready = en[0];
  assign dn_valid = v_r[Q_W-1];
  assign dn_word  = st_r[Q_W-1];
  assign link[0]  = up_word;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    div_t nxt;

    assign link[k+1] = st_r[k];

    always_comb begin
      nxt = link[k];
      for (int l = 0; l < NWHL; l++) begin
        if (link[k].rem[l] >= (NUM_W'(link[k].den) << SH)) begin
          nxt.rem[l]     = link[k].rem[l] - (NUM_W'(link[k].den) << SH);
          nxt.quo[l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

endmodule

### sv/mecanum_wheel_mixer.sv
// An input word passes 7 mixing stages, a 15-stage divider and one output register.
// Throughput: one word per cycle unless out_ch back-pressure stalls the pipeline.
// Backpressure holds each stage only while it and every stage after it are full.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults:
// offset 0, distance 3277, speed limit 16384.
module mecanum_wheel_mixer (
  input  logic       clk,
  input  logic       rst_n,
  mwm_in_if.sink     in_ch,
  mwm_out_if.source  out_ch,
  mwm_cfg_if.sink    cfg_ch
);
  import mwm_pkg::*;

  coef_t coef;
  cmd_t  cmd;
  logic  fr_valid, fr_ready;
  logic  dv_valid, dv_ready;
  div_t  fr_word, dv_word;

  logic                       out_valid_r, out_valid_nxt, out_en;
  logic [NWHL-1:0][OUT_W-1:0] res_r, res_nxt;
  logic                       scaled_r;

  assign cmd.vel_x    = in_ch.vel_x;
  assign cmd.vel_y    = in_ch.vel_y;
  assign cmd.yaw_rate = in_ch.yaw_rate;
  assign cmd.raw_mode = in_ch.raw_mode;

  mwm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .coef   (coef)
  );

  mwm_mix_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_cmd   (cmd),
    .dn_valid (fr_valid),
    .dn_ready (fr_ready),
    .dn_word  (fr_word)
  );

  mwm_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_word  (fr_word),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_word  (dv_word)
  );

  assign out_en        = ~out_valid_r | out_ch.ready;
  assign dv_ready      = out_en;
  assign out_valid_nxt = out_en ? dv_valid : out_valid_r;

  always_comb begin
    for (int l = 0; l < NWHL; l++) begin
      logic signed [OUT_W-1:0] qv;
      qv = $signed(OUT_W'(dv_word.quo[l]));
      if (dv_word.scale) begin
        res_nxt[l] = dv_word.neg[l] ? -qv : qv;
      end else begin
        res_nxt[l] = sat_out($signed(dv_word.whl[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      res_r    <= res_nxt;
      scaled_r <= dv_word.scale;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.wheel_front_a = res_r[0];
  assign out_ch.wheel_front_b = res_r[1];
  assign out_ch.wheel_rear_a  = res_r[2];
  assign out_ch.wheel_rear_b  = res_r[3];
  assign out_ch.was_scaled    = scaled_r;

endmodule
